/* rtl/fpec_pkg.sv */
// fpec_pkg: types, constants and helpers of the flash program/erase controller
// no dependencies; used by fpec_core and the top level by scoped names
`timescale 1ns / 1ps

package fpec_pkg;

    // array geometry
    localparam int FLASH_HWORDS          = 32768;
    localparam int PAGE_HWORDS           = 512;
    localparam int PAGES_PER_PROTECT_BIT = 2;
    localparam int ADDR_W                = $clog2(FLASH_HWORDS);
    localparam int PAGE_W                = $clog2(PAGE_HWORDS);
    localparam int PROT_SHIFT            = PAGE_W + $clog2(PAGES_PER_PROTECT_BIT);
    localparam int HW_W                  = 16;

    // unlock keys
    localparam logic [31:0] KEY_ONE = 32'h4567_0123;
    localparam logic [31:0] KEY_TWO = 32'hCDEF_89AB;

    // commands
    localparam logic [2:0] CMD_REG_READ  = 3'd0;
    localparam logic [2:0] CMD_REG_WRITE = 3'd1;
    localparam logic [2:0] CMD_HW_WRITE  = 3'd2;
    localparam logic [2:0] CMD_HW_READ   = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    // bus register indexes
    localparam logic [3:0] REG_ACR  = 4'd0;
    localparam logic [3:0] REG_KEYR = 4'd1;
    localparam logic [3:0] REG_SR   = 4'd3;
    localparam logic [3:0] REG_CR   = 4'd4;
    localparam logic [3:0] REG_AR   = 4'd5;
    localparam logic [3:0] REG_WRPR = 4'd8;

    // SR and CR bit positions
    localparam int SR_BSY    = 0;
    localparam int SR_PGERR  = 2;
    localparam int SR_WRPERR = 4;
    localparam int SR_EOP    = 5;
    localparam int CR_PG     = 0;
    localparam int CR_PER    = 1;
    localparam int CR_STRT   = 6;
    localparam int CR_LOCK   = 7;
    localparam int ACR_W     = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_ERASE_TICKS   = 2'd0;
    localparam logic [1:0] CFG_PROGRAM_TICKS = 2'd1;
    localparam logic [1:0] CFG_PROTECT_MASK  = 2'd2;

    localparam logic [15:0] ERASE_TICKS_RST   = 16'd20000;
    localparam logic [15:0] PROGRAM_TICKS_RST = 16'd60;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [3:0]        reg_index;
        logic [ADDR_W-1:0] flash_addr;
        logic [31:0]       write_data;
    } t_fpec_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        accepted;
    } t_fpec_out;

    typedef struct packed {
        logic [15:0] erase_ticks;
        logic [15:0] program_ticks;
        logic [31:0] protect_mask;
    } t_fpec_cfg;

    // a tick count of zero behaves as one
    function automatic logic [15:0] ticks_or_one(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // protect bit lookup, pages past bit 31 share bit 31
    function automatic logic page_protected(input logic [31:0] mask,
                                            input logic [ADDR_W-1:0] hw);
        logic [ADDR_W-1:0] sel;
        sel = hw >> PROT_SHIFT;
        if (sel > ADDR_W'(31)) begin
            sel = ADDR_W'(31);
        end
        return mask[sel[4:0]];
    endfunction

endpackage

/* rtl/fpec_ram.sv */
// fpec_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fpec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fpec_core.sv */
// fpec_core: sequencer, bus registers, status and output register of the controller
// depends on fpec_pkg and fpec_ram
`timescale 1ns / 1ps

module fpec_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpec_pkg::t_fpec_cfg i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fpec_pkg::t_fpec_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fpec_pkg::t_fpec_out o_out
);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_ERASE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int AW = fpec_pkg::ADDR_W;
    localparam int PW = fpec_pkg::PAGE_W;

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_cnt, n_cnt;
    fpec_pkg::t_fpec_in       r_item, n_item;
    fpec_pkg::t_fpec_out      r_res, n_res;
    fpec_pkg::t_fpec_out      r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     r_locked, n_locked;
    logic                     r_key_first, n_key_first;
    logic                     r_key_lockout, n_key_lockout;
    logic                     r_pg, n_pg;
    logic                     r_per, n_per;
    logic                     r_strt, n_strt;
    logic [31:0]              r_ar, n_ar;
    logic                     r_eop, n_eop;
    logic                     r_pgerr, n_pgerr;
    logic                     r_wrperr, n_wrperr;
    logic [15:0]              r_busy, n_busy;
    logic [fpec_pkg::ACR_W-1:0] r_acr, n_acr;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [fpec_pkg::HW_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [fpec_pkg::HW_W-1:0] ram_rdata;

    logic                     busy;
    logic [AW-1:0]            ar_hw;
    logic [31:0]              wd;
    logic [31:0]              reg_rd;

    assign busy  = (r_busy != 16'd0);
    assign ar_hw = r_ar[AW:1];
    assign wd    = r_item.write_data;

    // flash array storage
    fpec_ram #(
        .WIDTH(fpec_pkg::HW_W),
        .DEPTH(fpec_pkg::FLASH_HWORDS)
    ) u_array (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_item.flash_addr),
        .o_rdata(ram_rdata)
    );

    // bus register read mux
    always_comb begin
        reg_rd = 32'd0;
        case (r_item.reg_index)
            fpec_pkg::REG_ACR: reg_rd = {{(32-fpec_pkg::ACR_W){1'b0}}, r_acr};
            fpec_pkg::REG_SR: begin
                reg_rd[fpec_pkg::SR_BSY]    = busy;
                reg_rd[fpec_pkg::SR_PGERR]  = r_pgerr;
                reg_rd[fpec_pkg::SR_WRPERR] = r_wrperr;
                reg_rd[fpec_pkg::SR_EOP]    = r_eop;
            end
            fpec_pkg::REG_CR: begin
                reg_rd[fpec_pkg::CR_PG]   = r_pg;
                reg_rd[fpec_pkg::CR_PER]  = r_per;
                reg_rd[fpec_pkg::CR_STRT] = r_strt;
                reg_rd[fpec_pkg::CR_LOCK] = r_locked;
            end
            fpec_pkg::REG_AR:   reg_rd = r_ar;
            fpec_pkg::REG_WRPR: reg_rd = ~i_cfg.protect_mask;
            default:            reg_rd = 32'd0;
        endcase
    end

    // sequencer and register next state
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_item        = r_item;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_out_stall;
        n_locked      = r_locked;
        n_key_first   = r_key_first;
        n_key_lockout = r_key_lockout;
        n_pg          = r_pg;
        n_per         = r_per;
        n_strt        = r_strt;
        n_ar          = r_ar;
        n_eop         = r_eop;
        n_pgerr       = r_pgerr;
        n_wrperr      = r_wrperr;
        n_busy        = r_busy;
        n_acr         = r_acr;
        ram_we        = 1'b0;
        ram_waddr     = r_cnt;
        ram_wdata     = '1;
        ram_re        = 1'b0;

        case (r_state)
            // fill the whole array with the erased value after reset
            S_CLEAR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_EXEC;
                end
            end

            // decode one transaction
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_item.cmd)
                    fpec_pkg::CMD_REG_READ: n_res.read_data = reg_rd;

                    fpec_pkg::CMD_REG_WRITE: begin
                        case (r_item.reg_index)
                            fpec_pkg::REG_ACR: begin
                                n_acr          = wd[fpec_pkg::ACR_W-1:0];
                                n_res.accepted = 1'b1;
                            end
                            // key sequence, any wrong key while locked locks out until reset
                            fpec_pkg::REG_KEYR: begin
                                if (!r_key_lockout && r_locked) begin
                                    if (!r_key_first && wd == fpec_pkg::KEY_ONE) begin
                                        n_key_first    = 1'b1;
                                        n_res.accepted = 1'b1;
                                    end else if (r_key_first && wd == fpec_pkg::KEY_TWO) begin
                                        n_key_first    = 1'b0;
                                        n_locked       = 1'b0;
                                        n_res.accepted = 1'b1;
                                    end else begin
                                        n_key_first   = 1'b0;
                                        n_key_lockout = 1'b1;
                                    end
                                end
                            end
                            // write one to clear
                            fpec_pkg::REG_SR: begin
                                if (wd[fpec_pkg::SR_EOP])    n_eop    = 1'b0;
                                if (wd[fpec_pkg::SR_PGERR])  n_pgerr  = 1'b0;
                                if (wd[fpec_pkg::SR_WRPERR]) n_wrperr = 1'b0;
                                n_res.accepted = 1'b1;
                            end
                            fpec_pkg::REG_CR: begin
                                if (!r_locked && !busy) begin
                                    n_res.accepted = 1'b1;
                                    n_pg   = wd[fpec_pkg::CR_PG];
                                    n_per  = wd[fpec_pkg::CR_PER];
                                    n_strt = 1'b0;
                                    if (wd[fpec_pkg::CR_LOCK]) begin
                                        n_locked = 1'b1;
                                    end else if (wd[fpec_pkg::CR_STRT] && wd[fpec_pkg::CR_PER]) begin
                                        if (fpec_pkg::page_protected(i_cfg.protect_mask, ar_hw)) begin
                                            n_wrperr = 1'b1;
                                        end else begin
                                            // page erase sweep from the page base
                                            n_strt  = 1'b1;
                                            n_busy  = fpec_pkg::ticks_or_one(i_cfg.erase_ticks);
                                            n_cnt   = {ar_hw[AW-1:PW], {PW{1'b0}}};
                                            n_state = S_ERASE;
                                        end
                                    end
                                end
                            end
                            fpec_pkg::REG_AR: begin
                                if (!r_locked && !busy) begin
                                    n_ar           = wd;
                                    n_res.accepted = 1'b1;
                                end
                            end
                            default: n_res.accepted = 1'b0;
                        endcase
                    end

                    // halfword program: checks first, then read the target
                    fpec_pkg::CMD_HW_WRITE: begin
                        if (!r_locked && !busy && r_pg) begin
                            if (fpec_pkg::page_protected(i_cfg.protect_mask,
                                                         r_item.flash_addr)) begin
                                n_wrperr       = 1'b1;
                                n_res.accepted = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_RDWAIT;
                            end
                        end
                    end

                    fpec_pkg::CMD_HW_READ: begin
                        ram_re  = 1'b1;
                        n_state = S_RDWAIT;
                    end

                    // busy countdown, end of operation on the last tick
                    fpec_pkg::CMD_TICK: begin
                        if (busy) begin
                            n_busy = r_busy - 16'd1;
                            if (r_busy == 16'd1) begin
                                n_eop  = 1'b1;
                                n_strt = 1'b0;
                            end
                        end
                    end

                    default: n_res = '0;
                endcase
            end

            // array data is back
            S_RDWAIT: begin
                n_state = S_DONE;
                if (r_item.cmd == fpec_pkg::CMD_HW_READ) begin
                    n_res.read_data = {{(32-fpec_pkg::HW_W){1'b0}}, ram_rdata};
                end else if (ram_rdata != '1 && wd[fpec_pkg::HW_W-1:0] != '0) begin
                    n_pgerr        = 1'b1;
                    n_res.accepted = 1'b0;
                end else begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_item.flash_addr;
                    ram_wdata      = wd[fpec_pkg::HW_W-1:0];
                    n_busy         = fpec_pkg::ticks_or_one(i_cfg.program_ticks);
                    n_res.accepted = 1'b1;
                end
            end

            // one halfword of the page per cycle
            S_ERASE: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt[PW-1:0] == '1) begin
                    n_state = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_locked      <= 1'b1;
            r_key_first   <= 1'b0;
            r_key_lockout <= 1'b0;
            r_pg          <= 1'b0;
            r_per         <= 1'b0;
            r_strt        <= 1'b0;
            r_ar          <= '0;
            r_eop         <= 1'b0;
            r_pgerr       <= 1'b0;
            r_wrperr      <= 1'b0;
            r_busy        <= '0;
            r_acr         <= '0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
            r_locked      <= n_locked;
            r_key_first   <= n_key_first;
            r_key_lockout <= n_key_lockout;
            r_pg          <= n_pg;
            r_per         <= n_per;
            r_strt        <= n_strt;
            r_ar          <= n_ar;
            r_eop         <= n_eop;
            r_pgerr       <= n_pgerr;
            r_wrperr      <= n_wrperr;
            r_busy        <= n_busy;
            r_acr         <= n_acr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/flash_program_erase_controller.sv */
// flash_program_erase_controller: top level with the apb configuration registers
// depends on fpec_pkg and fpec_core
`timescale 1ns / 1ps

// Flash program/erase controller with key unlock. Each input transaction is one
// bus access (register read or write, halfword program or read, or tick) and
// yields exactly one result transaction. A single sequencer runs one
// transaction at a time. Halfword reads and programs pass through a registered
// array read before the compare and write (a program that is refused or hits a
// protected page skips the read), and a page erase sweeps the single array
// write port one halfword per cycle. The sequencer passes through its idle
// state before the next input transaction is accepted. A result waits in an
// output register, so the next input transaction is accepted while it is
// stalled. After reset the array is filled with ones by a clearing pass over
// all FLASH_HWORDS halfwords (32768) during which no input transaction is
// accepted; APB configuration writes are taken at any time.
module flash_program_erase_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fpec_pkg::t_fpec_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fpec_pkg::t_fpec_out o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    fpec_pkg::t_fpec_cfg r_cfg;
    logic                cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.erase_ticks   <= fpec_pkg::ERASE_TICKS_RST;
            r_cfg.program_ticks <= fpec_pkg::PROGRAM_TICKS_RST;
            r_cfg.protect_mask  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                fpec_pkg::CFG_ERASE_TICKS:   r_cfg.erase_ticks   <= pwdata[15:0];
                fpec_pkg::CFG_PROGRAM_TICKS: r_cfg.program_ticks <= pwdata[15:0];
                fpec_pkg::CFG_PROTECT_MASK:  r_cfg.protect_mask  <= pwdata;
                default:                     r_cfg               <= r_cfg;
            endcase
        end
    end

    // configuration register reads
    always_comb begin
        case (paddr[3:2])
            fpec_pkg::CFG_ERASE_TICKS:   prdata = {16'd0, r_cfg.erase_ticks};
            fpec_pkg::CFG_PROGRAM_TICKS: prdata = {16'd0, r_cfg.program_ticks};
            fpec_pkg::CFG_PROTECT_MASK:  prdata = r_cfg.protect_mask;
            default:                     prdata = 32'd0;
        endcase
    end

    fpec_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule
